// File: rtl/core/dsao_pkg.sv
// ----------------------------------------------------------------------------
// Dual-stack address orderer package
// Entry record, preference scoring and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dsao_pkg;

  localparam int TAG_W  = 16;
  localparam int PREF_W = 5;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V6   = 2'd2;
  localparam logic [2:0] SCOPE_MAX = 3'd5;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic signed [PREF_W-1:0] pref;
    logic              v6;
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SPLIT,
    ST_EMIT
  } state_t;

  function automatic entry_t make_entry(input logic [TAG_W-1:0] tag,
                                        input logic [2:0] scope,
                                        input logic [1:0] fam,
                                        input logic mapped);
    entry_t e;
    logic [2:0] rank;
    e.tag = tag;
    e.v6  = (fam == FAM_V6) && !mapped;
    rank  = (scope <= SCOPE_MAX) ? scope : 3'd0;
    if (fam == FAM_NONE) e.pref = -5'sd1;
    else e.pref = $signed({1'b0, rank, e.v6});
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dsao_sort_cell.sv
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one entry of the descending insertion chain; can also shift
// towards the head for draining.
// ----------------------------------------------------------------------------
`default_nettype none

module dsao_sort_cell
  import dsao_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   clear,
  input  wire logic   insert,
  input  wire logic   shift,
  input  wire entry_t new_entry,
  input  wire logic   prev_valid,
  input  wire logic   prev_takes,
  input  wire entry_t prev_entry,
  input  wire logic   next_valid,
  input  wire entry_t next_entry,
  output logic        valid,
  output logic        takes,
  output entry_t      entry
);

  logic here;

  // Strict compare keeps equal preferences in arrival order.
  assign here  = !valid || (entry.pref < new_entry.pref);
  assign takes = here;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
      entry <= next_entry;
    end else if (insert && here) begin
      // Behind the insertion point every cell takes over its predecessor.
      if (prev_takes) begin
        valid <= prev_valid;
        entry <= prev_entry;
      end else begin
        valid <= 1'b1;
        entry <= new_entry;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dsao_fifo_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// One stage of a shift-towards-head queue used per address family.
// ----------------------------------------------------------------------------
`default_nettype none

module dsao_fifo_cell
  import dsao_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   clear,
  input  wire logic   pop,
  input  wire logic   push_here,
  input  wire entry_t push_entry,
  input  wire logic   next_valid,
  input  wire entry_t next_entry,
  output logic        valid,
  output entry_t      entry
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (push_here) begin
      valid <= 1'b1;
      entry <= push_entry;
    end else if (pop) begin
      valid <= next_valid;
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dual_stack_address_orderer.sv
// ----------------------------------------------------------------------------
// Dual-stack address orderer
// Sorts candidate destinations by preference; up to a set limit, interleaves families.
// ----------------------------------------------------------------------------
// Loading inserts each entry into a sorted chain of cells.
// On the closing entry, a split pass moves the sorted list into the family
// queues (all into q4 when not interleaving); emission then gives one
// result per cycle while m_axis_tready is high.
// Reset empties the chain, clears count and overflow and sets the limit to 16.
`default_nettype none

module dual_stack_address_orderer
  import dsao_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: entry_tag[15:0], scope_class[18:16], addr_family[20:19],
  // v4_mapped[21], zeros[23:22]
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_tag[15:0], preference[20:16], native_v6[21], overflowed[22], zero[23]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int N  = STORE_DEPTH;

  state_t state, state_next;
  logic [5:0]    interleave_limit;
  logic [CW-1:0] entry_count, left;
  logic          overflow_flag;
  logic          take6;

  entry_t in_e;
  logic   acc_in, full, ins, shift_s, clear_all;

  logic   sv [N+2];
  entry_t se [N+2];
  logic   st [N+1];
  logic   f6v [N+1], f4v [N+1];
  entry_t f6e [N+1], f4e [N+1];
  logic [CW-1:0] n6, n4;
  logic   pop6, pop4, push6, push4, use6, interleave;

  assign in_e = make_entry(s_axis_tdata[15:0], s_axis_tdata[18:16],
                           s_axis_tdata[20:19], s_axis_tdata[21]);
  assign s_axis_tready = (state == ST_LOAD);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign full   = (entry_count == CW'(N));
  assign ins    = acc_in && !full;

  assign sv[0] = 1'b0; assign se[0] = '0; assign st[0] = 1'b0;
  assign sv[N+1] = 1'b0; assign se[N+1] = '0;
  assign f6v[N] = 1'b0; assign f6e[N] = '0;
  assign f4v[N] = 1'b0; assign f4e[N] = '0;

  assign push6 = shift_s && sv[1] && interleave && se[1].v6;
  assign push4 = shift_s && sv[1] && !(interleave && se[1].v6);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cells
      // Cell g drives index g+1; its neighbours sit at g and g+2.
      dsao_sort_cell u_sort (
        .clk, .rst, .clear(clear_all), .insert(ins), .shift(shift_s),
        .new_entry(in_e), .prev_valid(sv[g]), .prev_takes(st[g]),
        .prev_entry(se[g]), .next_valid(sv[g+2]), .next_entry(se[g+2]),
        .valid(sv[g+1]), .takes(st[g+1]), .entry(se[g+1])
      );
      dsao_fifo_cell u_q6 (
        .clk, .rst, .clear(clear_all), .pop(pop6),
        .push_here(push6 && (n6 == CW'(g))), .push_entry(se[1]),
        .next_valid(f6v[g+1]), .next_entry(f6e[g+1]),
        .valid(f6v[g]), .entry(f6e[g])
      );
      dsao_fifo_cell u_q4 (
        .clk, .rst, .clear(clear_all), .pop(pop4),
        .push_here(push4 && (n4 == CW'(g))), .push_entry(se[1]),
        .next_valid(f4v[g+1]), .next_entry(f4e[g+1]),
        .valid(f4v[g]), .entry(f4e[g])
      );
    end
  endgenerate

  // Chain head index 0 is the cell g=0, so its outputs sit in sv[1]/se[1].
  assign interleave = (entry_count >= CW'(2)) &&
                      (32'(interleave_limit) >= 32'(entry_count));

  // Without interleaving the v6 queue is unused: everything goes through q4.
  always_comb begin
    if (!f6v[0]) use6 = 1'b0;
    else if (!f4v[0]) use6 = 1'b1;
    else use6 = take6;
  end

  logic emit_fire;
  assign m_axis_tvalid = (state == ST_EMIT);
  assign emit_fire = m_axis_tvalid && m_axis_tready;
  assign pop6 = emit_fire && use6;
  assign pop4 = emit_fire && !use6;
  assign m_axis_tlast = (left == CW'(1));
  always_comb begin
    entry_t o;
    o = use6 ? f6e[0] : f4e[0];
    m_axis_tdata = {1'b0, overflow_flag, o.v6, o.pref, o.tag};
  end

  always_comb begin
    state_next = state;
    shift_s    = 1'b0;
    clear_all  = 1'b0;
    unique case (state)
      ST_LOAD:  if (acc_in && s_axis_tlast) state_next = ST_SPLIT;
      ST_SPLIT: begin
        shift_s = sv[1];
        if (!sv[1]) state_next = (entry_count == '0) ? ST_LOAD : ST_EMIT;
      end
      ST_EMIT: if (emit_fire && left == CW'(1)) begin
        state_next = ST_LOAD;
        clear_all  = 1'b1;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      interleave_limit <= 6'd16;
      entry_count <= '0;
      overflow_flag <= 1'b0;
      n6 <= '0; n4 <= '0; left <= '0; take6 <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) interleave_limit <= cfg_wdata;
      if (ins) entry_count <= entry_count + CW'(1);
      if (acc_in && full) overflow_flag <= 1'b1;
      if (state == ST_SPLIT && state_next == ST_LOAD) begin
        overflow_flag <= 1'b0;
      end
      if (shift_s) begin
        if (interleave && se[1].v6) n6 <= n6 + CW'(1);
        else n4 <= n4 + CW'(1);
        if (n6 == '0 && n4 == '0) take6 <= interleave && se[1].v6;
      end
      if (state == ST_SPLIT && !sv[1]) left <= entry_count;
      if (emit_fire) begin
        left  <= left - CW'(1);
        take6 <= !use6;
      end
      if (clear_all) begin
        entry_count <= '0; overflow_flag <= 1'b0;
        n6 <= '0; n4 <= '0;
      end
    end
  end

endmodule

`default_nettype wire
